// File: rtl/planar_chain_end_position_assert.svh
// Assertion macros for the planar chain end position block.
`ifndef PLANAR_CHAIN_END_POSITION_ASSERT_SVH
`define PLANAR_CHAIN_END_POSITION_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define PCEP_ASSERT_IMPLY(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pcep implication check failed");

// Condition that holds on every rising edge outside reset.
`define PCEP_ASSERT_ALWAYS(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("pcep invariant check failed");

`endif

// File: rtl/pcep_pkg.sv
// Types, constants and trig tables for the planar chain end position block.
package pcep_pkg;

   localparam int MAX_SEGMENTS = 1024;
   localparam int ADDR_BITS    = $clog2(MAX_SEGMENTS);
   localparam int LENGTH_BITS  = 10;
   localparam int COUNT_BITS   = 11;
   localparam int ROT_BITS     = 9;
   localparam int ENTRY_BITS   = LENGTH_BITS + ROT_BITS;
   localparam int TRIG_BITS    = 16;
   localparam int PROD_BITS    = LENGTH_BITS + 1 + TRIG_BITS;
   localparam int OUT_BITS     = 36;
   localparam int DEG_FULL     = 360;
   localparam int DEG_HALF     = 180;
   localparam int DEG_QUARTER  = 90;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_JOINT = 1'b1;

   localparam logic [63:0] DEG_Q32 = 64'd74961321;
   localparam logic [63:0] ONE_Q32 = 64'd4294967296;

   typedef struct packed {
      logic       kind;
      logic [9:0] index;
      logic [9:0] amount;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] end_x;
      logic signed [OUT_BITS-1:0] end_y;
   } rsp_payload_type;

   typedef logic signed [TRIG_BITS-1:0] trig_rom_type [DEG_FULL];

   // long division, used only while building the tables
   function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] series_q32(logic [63:0] x, logic odd);
      logic [63:0]        t;
      logic [63:0]        k;
      logic signed [63:0] acc;
      t   = odd ? x : ONE_Q32;
      acc = signed'(t);
      for (int n = 1; n <= 9; n++) begin
         k = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
         t = (t * x) >> 32;
         t = (t * x) >> 32;
         t = div_u64(t, k);
         if ((n % 2) == 1) begin
            acc = acc - signed'(t);
         end else begin
            acc = acc + signed'(t);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return unsigned'(acc);
   endfunction

   function automatic logic [15:0] quarter_sine(int k);
      logic [63:0] v;
      logic [63:0] r;
      if (k <= 45) begin
         v = series_q32(64'(k) * DEG_Q32, 1'b1);
      end else begin
         v = series_q32(64'(DEG_QUARTER - k) * DEG_Q32, 1'b0);
      end
      r = (v + 64'd65536) >> 17;
      if (r > 64'd32767) begin
         r = 64'd32767;
      end
      return r[15:0];
   endfunction

   function automatic trig_rom_type build_sine_table();
      trig_rom_type      table_out;
      logic [15:0]       q [DEG_QUARTER + 1];
      for (int k = 0; k <= DEG_QUARTER; k++) begin
         q[k] = quarter_sine(k);
      end
      for (int k = 0; k < DEG_FULL; k++) begin
         if (k <= DEG_QUARTER) begin
            table_out[k] = signed'(q[k]);
         end else if (k <= DEG_HALF) begin
            table_out[k] = signed'(q[DEG_HALF - k]);
         end else if (k <= DEG_HALF + DEG_QUARTER) begin
            table_out[k] = -signed'(q[k - DEG_HALF]);
         end else begin
            table_out[k] = -signed'(q[DEG_FULL - k]);
         end
      end
      return table_out;
   endfunction

   function automatic trig_rom_type build_cosine_table();
      trig_rom_type s;
      trig_rom_type c;
      s = build_sine_table();
      for (int k = 0; k < DEG_FULL; k++) begin
         if (k + DEG_QUARTER >= DEG_FULL) begin
            c[k] = s[k + DEG_QUARTER - DEG_FULL];
         end else begin
            c[k] = s[k + DEG_QUARTER];
         end
      end
      return c;
   endfunction

   localparam trig_rom_type SINE_TABLE   = build_sine_table();
   localparam trig_rom_type COSINE_TABLE = build_cosine_table();

endpackage

// File: rtl/planar_chain_end_position.sv
// Top level of the planar chain end position block: segment memory, sweep and accumulators.
// After reset the segment memory is cleared one entry a cycle, during which no item is
// accepted (csr writes are taken). A load beat does not stall the input. An angle beat
// stalls the input while the entries at its joint are read and the rotation delta is
// formed (when its joint is in range), while the n active segments are swept and drained
// (none for an empty chain), n being the active segment count, and while it waits for the
// output register: the single read port of the segment memory delivers one segment per
// cycle to the rotate, table lookup, multiply and accumulate pipeline. One result is held
// in the output register, so the next beat is accepted while it waits to be taken.
module planar_chain_end_position (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pcep_pkg::req_payload_type          req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pcep_pkg::rsp_payload_type          rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pcep_pkg::COUNT_BITS-1:0]    csr_data
);
   import pcep_pkg::*;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_READ_LO = 3'd2;
   localparam logic [2:0] ST_READ_HI = 3'd3;
   localparam logic [2:0] ST_DELTA   = 3'd4;
   localparam logic [2:0] ST_SWEEP   = 3'd5;
   localparam logic [2:0] ST_DRAIN   = 3'd6;
   localparam logic [2:0] ST_FINISH  = 3'd7;

   logic [ENTRY_BITS-1:0]       seg_mem [MAX_SEGMENTS];
   logic [ENTRY_BITS-1:0]       mem_q_ff;

   logic [2:0]                  state_ff, state_in;
   logic [COUNT_BITS-1:0]       segment_count_ff;
   logic [ADDR_BITS-1:0]        clr_ff;
   logic [ADDR_BITS-1:0]        sweep_ff;
   logic [ADDR_BITS-1:0]        joint_ff;
   logic [ROT_BITS-1:0]         angle_ff;
   logic [COUNT_BITS-1:0]       n_ff;
   logic                        upd_ff;
   logic [ROT_BITS-1:0]         rot_lo_ff;
   logic [ROT_BITS-1:0]         delta_ff;

   logic                        rd_valid_ff;
   logic [ADDR_BITS-1:0]        rd_idx_ff;
   logic                        v1_ff, v2_ff, v3_ff;
   logic [LENGTH_BITS-1:0]      len1_ff, len2_ff;
   logic [ROT_BITS-1:0]         rot1_ff;
   logic signed [TRIG_BITS-1:0] sin2_ff, cos2_ff;
   logic signed [PROD_BITS-1:0] px3_ff, py3_ff;
   logic signed [OUT_BITS-1:0]  acc_x_ff, acc_y_ff;

   logic                        rsp_valid_ff;
   rsp_payload_type             rsp_data_ff;

   logic                        req_accept;
   logic                        start_joint;
   logic                        out_free;
   logic [COUNT_BITS-1:0]       count_eff;
   logic                        joint_ok;
   logic                        rd_en;
   logic [ADDR_BITS-1:0]        rd_addr;
   logic                        wr_en;
   logic [ADDR_BITS-1:0]        wr_addr;
   logic [ENTRY_BITS-1:0]       wr_data;
   logic [LENGTH_BITS-1:0]      q_len;
   logic [ROT_BITS-1:0]         q_rot;
   logic                        bump;
   logic [ROT_BITS:0]           rot_sum;
   logic [ROT_BITS-1:0]         rot_new;
   logic [COUNT_BITS-1:0]       delta_sum;

   function automatic logic [ROT_BITS-1:0] wrap_degrees(logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      if (v >= COUNT_BITS'(3 * DEG_FULL)) begin
         r = v - COUNT_BITS'(3 * DEG_FULL);
      end else if (v >= COUNT_BITS'(2 * DEG_FULL)) begin
         r = v - COUNT_BITS'(2 * DEG_FULL);
      end else if (v >= COUNT_BITS'(DEG_FULL)) begin
         r = v - COUNT_BITS'(DEG_FULL);
      end else begin
         r = v;
      end
      return r[ROT_BITS-1:0];
   endfunction

   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;
   assign start_joint = req_accept && (req_data.kind == KIND_JOINT);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

   assign count_eff = (segment_count_ff > COUNT_BITS'(MAX_SEGMENTS)) ?
                      COUNT_BITS'(MAX_SEGMENTS) : segment_count_ff;
   assign joint_ok  = (COUNT_BITS'(req_data.index) + COUNT_BITS'(1)) < count_eff;

   assign q_len   = mem_q_ff[ENTRY_BITS-1:ROT_BITS];
   assign q_rot   = mem_q_ff[ROT_BITS-1:0];
   assign bump    = upd_ff && (rd_idx_ff > joint_ff);
   assign rot_sum = (ROT_BITS+1)'(q_rot) + (ROT_BITS+1)'(delta_ff);
   assign rot_new = !bump ? q_rot :
                    (rot_sum >= (ROT_BITS+1)'(DEG_FULL)) ?
                    ROT_BITS'(rot_sum - (ROT_BITS+1)'(DEG_FULL)) : rot_sum[ROT_BITS-1:0];

   assign delta_sum = COUNT_BITS'(DEG_HALF) + COUNT_BITS'(angle_ff) + COUNT_BITS'(rot_lo_ff)
                    + COUNT_BITS'(DEG_FULL) - COUNT_BITS'(q_rot);

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = sweep_ff;
      unique case (state_ff)
         ST_READ_LO: begin
            rd_en   = 1'b1;
            rd_addr = joint_ff;
         end
         ST_READ_HI: begin
            rd_en   = 1'b1;
            rd_addr = joint_ff + ADDR_BITS'(1);
         end
         ST_SWEEP: begin
            rd_en   = 1'b1;
            rd_addr = sweep_ff;
         end
         default: begin
            rd_en   = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = {q_len, rot_new};
      priority if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (req_accept && (req_data.kind == KIND_LOAD) &&
                   (int'(req_data.index) < MAX_SEGMENTS)) begin
         wr_en   = 1'b1;
         wr_addr = ADDR_BITS'(req_data.index);
         wr_data = {req_data.amount[LENGTH_BITS-1:0], ROT_BITS'(0)};
      end else if (rd_valid_ff && bump) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
         wr_data = {q_len, rot_new};
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seg_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= seg_mem[rd_addr];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ADDR_BITS'(MAX_SEGMENTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start_joint) begin
               priority if (joint_ok) begin
                  state_in = ST_READ_LO;
               end else if (count_eff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_READ_LO: state_in = ST_READ_HI;
         ST_READ_HI: state_in = ST_DELTA;
         ST_DELTA:   state_in = ST_SWEEP;
         ST_SWEEP: begin
            if (COUNT_BITS'(sweep_ff) == n_ff - COUNT_BITS'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !v1_ff && !v2_ff && !v3_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         segment_count_ff <= COUNT_BITS'(1);
         clr_ff           <= '0;
         rd_valid_ff      <= 1'b0;
         v1_ff            <= 1'b0;
         v2_ff            <= 1'b0;
         v3_ff            <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= (state_ff == ST_SWEEP);
         v1_ff       <= rd_valid_ff;
         v2_ff       <= v1_ff;
         v3_ff       <= v2_ff;
         if (csr_valid && csr_ready) begin
            segment_count_ff <= csr_data;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_BITS'(1);
         end
         if ((state_ff == ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_joint) begin
         joint_ff <= ADDR_BITS'(req_data.index);
         angle_ff <= wrap_degrees(COUNT_BITS'(req_data.amount));
         n_ff     <= count_eff;
         upd_ff   <= joint_ok;
         sweep_ff <= '0;
      end else if (state_ff == ST_SWEEP) begin
         sweep_ff <= sweep_ff + ADDR_BITS'(1);
      end
      if (state_ff == ST_READ_HI) begin
         rot_lo_ff <= q_rot;
      end
      if (state_ff == ST_DELTA) begin
         delta_ff <= wrap_degrees(delta_sum);
      end
      rd_idx_ff <= sweep_ff;
      len1_ff   <= q_len;
      rot1_ff   <= rot_new;
      len2_ff   <= len1_ff;
      sin2_ff   <= SINE_TABLE[rot1_ff];
      cos2_ff   <= COSINE_TABLE[rot1_ff];
      px3_ff    <= signed'({1'b0, len2_ff}) * sin2_ff;
      py3_ff    <= signed'({1'b0, len2_ff}) * cos2_ff;
      if (start_joint) begin
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else if (v3_ff) begin
         acc_x_ff <= acc_x_ff - OUT_BITS'(px3_ff);
         acc_y_ff <= acc_y_ff + OUT_BITS'(py3_ff);
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_data_ff.end_x <= acc_x_ff;
         rsp_data_ff.end_y <= acc_y_ff;
      end
   end

`include "planar_chain_end_position_assert.svh"

   `PCEP_ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid), $past(state_ff) == ST_FINISH)
   `PCEP_ASSERT_IMPLY(a_no_same_entry, clock, reset, wr_en && rd_en, wr_addr != rd_addr)
   `PCEP_ASSERT_IMPLY(a_rot_in_range, clock, reset, wr_en, wr_data[ROT_BITS-1:0] < ROT_BITS'(DEG_FULL))
   `PCEP_ASSERT_ALWAYS(a_sweep_nonempty, clock, reset, (state_ff != ST_SWEEP) || (n_ff != '0))

endmodule

// File: sim/planar_chain_end_position_tb.sv
// Self-checking testbench for the planar chain end position block.
`timescale 1ns / 1ps

module planar_chain_end_position_tb;
   import pcep_pkg::*;

   localparam int          IDLE_LIMIT     = 5000;
   localparam int          SETTLE_CYCLES  = 16;
   localparam int          DRAIN_CYCLES   = 1100;
   localparam int          HOLD_OFF       = 300;
   localparam int          SHOWN_ERRORS   = 20;
   localparam logic [63:0] Q32_UNIT       = 64'h1_0000_0000;
   localparam logic [63:0] Q32_PER_DEGREE = 64'd74961321;

   class chain_end_tracker;
      bit [LENGTH_BITS-1:0] seg_len [MAX_SEGMENTS];
      bit [ROT_BITS-1:0]    seg_rot [MAX_SEGMENTS];
      logic signed [15:0]   sin_q15 [DEG_FULL];
      logic signed [15:0]   cos_q15 [DEG_FULL];
      int unsigned          seg_count;
      rsp_payload_type      expected_ends [$];
      int                   errors;
      int                   loads_seen;
      int                   angles_seen;
      int                   ends_checked;

      function new();
         seg_count = 1;
         build_trig();
      endfunction

      function logic [63:0] taylor_q32(logic [63:0] x, bit odd);
         logic [63:0] term;
         logic [63:0] div;
         longint      acc;
         term = odd ? x : Q32_UNIT;
         acc  = longint'(term);
         for (int n = 1; n <= 9; n++) begin
            div  = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
            term = (term * x) >> 32;
            term = (term * x) >> 32;
            term = term / div;
            if ((n % 2) == 1) begin
               acc -= longint'(term);
            end else begin
               acc += longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         return acc;
      endfunction

      function void build_trig();
         logic signed [15:0] quad [DEG_QUARTER + 1];
         logic [63:0]        v;
         logic [63:0]        r;
         for (int k = 0; k <= DEG_QUARTER; k++) begin
            if (k <= 45) begin
               v = taylor_q32(Q32_PER_DEGREE * 64'(k), 1'b1);
            end else begin
               v = taylor_q32(Q32_PER_DEGREE * 64'(DEG_QUARTER - k), 1'b0);
            end
            r = (v + 64'd65536) >> 17;
            if (r > 64'd32767) begin
               r = 64'd32767;
            end
            quad[k] = r[15:0];
         end
         for (int k = 0; k < DEG_FULL; k++) begin
            if (k <= DEG_QUARTER) begin
               sin_q15[k] = quad[k];
            end else if (k <= DEG_HALF) begin
               sin_q15[k] = quad[DEG_HALF - k];
            end else if (k <= DEG_HALF + DEG_QUARTER) begin
               sin_q15[k] = -quad[k - DEG_HALF];
            end else begin
               sin_q15[k] = -quad[DEG_FULL - k];
            end
         end
         for (int k = 0; k < DEG_FULL; k++) begin
            cos_q15[k] = sin_q15[(k + DEG_QUARTER) % DEG_FULL];
         end
      endfunction

      function void note_beat(req_payload_type beat);
         int              n;
         int              j;
         int              b;
         int              shift;
         int              r;
         longint          sx;
         longint          sy;
         rsp_payload_type end_pt;
         if (beat.kind == KIND_LOAD) begin
            seg_len[beat.index] = beat.amount;
            seg_rot[beat.index] = '0;
            loads_seen++;
            return;
         end
         angles_seen++;
         n = (seg_count > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(seg_count);
         j = int'(beat.index);
         if (j + 1 < n) begin
            b     = int'(seg_rot[j + 1]) - int'(seg_rot[j]);
            shift = (DEG_HALF + int'(beat.amount) - b) % DEG_FULL;
            if (shift < 0) begin
               shift += DEG_FULL;
            end
            for (int i = j + 1; i < n; i++) begin
               seg_rot[i] = ROT_BITS'((int'(seg_rot[i]) + shift) % DEG_FULL);
            end
         end
         sx = 0;
         sy = 0;
         for (int i = 0; i < n; i++) begin
            r  = int'(seg_rot[i]);
            sx -= longint'(seg_len[i]) * longint'(sin_q15[r]);
            sy += longint'(seg_len[i]) * longint'(cos_q15[r]);
         end
         end_pt.end_x = sx[OUT_BITS-1:0];
         end_pt.end_y = sy[OUT_BITS-1:0];
         expected_ends.push_back(end_pt);
      endfunction

      task report(string what);
         errors++;
         if (errors <= SHOWN_ERRORS) begin
            $display("mismatch: %s", what);
         end
      endtask

      task check_end_point(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_ends.size() == 0) begin
            report($sformatf("end point (%0d, %0d) with none pending", got.end_x, got.end_y));
            return;
         end
         want = expected_ends.pop_front();
         ends_checked++;
         if (got.end_x !== want.end_x) begin
            report($sformatf("end point %0d: end_x %0d, want %0d",
                             ends_checked, got.end_x, want.end_x));
         end
         if (got.end_y !== want.end_y) begin
            report($sformatf("end point %0d: end_y %0d, want %0d",
                             ends_checked, got.end_y, want.end_y));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_payload_type       rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_data;

   chain_end_tracker      tracker;
   bit                    loaded [MAX_SEGMENTS];
   bit                    no_idle;
   bit                    hold_off_req;
   int                    sizes_tried;
   int                    idle_cycles;

   planar_chain_end_position dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // receiver: random stalls, a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF;
         end
         if (stall_left == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         tracker.check_end_point(rsp_data);
      end
      if (!reset && req_valid && !req_stall) begin
         tracker.note_beat(req_data);
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("no beat for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic send_beat(req_payload_type beat);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_load(int idx, int len);
      req_payload_type beat;
      beat.kind   = KIND_LOAD;
      beat.index  = 10'(idx);
      beat.amount = 10'(len);
      loaded[idx] = 1'b1;
      send_beat(beat);
   endtask

   task automatic send_angle(int joint, int angle);
      req_payload_type beat;
      beat.kind   = KIND_JOINT;
      beat.index  = 10'(joint);
      beat.amount = 10'(angle);
      send_beat(beat);
   endtask

   task automatic write_segment_count(int unsigned value);
      req_valid <= 1'b0;
      while (tracker.expected_ends.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= COUNT_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      tracker.seg_count = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      sizes_tried++;
   endtask

   task automatic run_directed();
      send_load(0, 1023);
      send_angle(0, 0);
      send_angle(1023, 1023);
      send_load(0, 0);
      send_angle(0, 359);
      send_load(0, 512);
      write_segment_count(0);
      send_angle(0, 359);
      send_load(1023, 1023);
      send_angle(1023, 0);
      write_segment_count(4);
      send_load(0, 100);
      send_load(1, 200);
      send_load(2, 300);
      send_load(3, 1023);
      send_angle(0, 0);
      send_angle(1, 90);
      send_angle(2, 180);
      send_angle(2, 359);
      send_angle(0, 1023);
      send_angle(3, 45);
      send_load(2, 0);
      send_angle(1, 270);
      send_angle(1, 1022);
   endtask

   task automatic run_random_phase(int count, int beats, bit quiet, bit hold_off);
      int n;
      int roll;
      int joint;
      write_segment_count(count);
      no_idle = quiet;
      if (hold_off) begin
         hold_off_req = 1'b1;
      end
      n = (count > MAX_SEGMENTS) ? MAX_SEGMENTS : count;
      for (int i = 0; i < n; i++) begin
         if (!loaded[i]) begin
            send_load(i, $urandom_range(0, 1023));
         end
      end
      repeat (beats) begin
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            send_load($urandom_range(0, n - 1), $urandom_range(0, 1023));
         end else if (roll < 25) begin
            send_load($urandom_range(0, MAX_SEGMENTS - 1), $urandom_range(0, 1023));
         end else begin
            if (roll < 90 && n >= 2) begin
               joint = $urandom_range(0, n - 2);
            end else begin
               joint = $urandom_range(0, MAX_SEGMENTS - 1);
            end
            send_angle(joint, (roll % 3 != 0) ? $urandom_range(0, DEG_FULL - 1)
                                              : $urandom_range(0, 1023));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      int phase_sizes [9];
      phase_sizes  = '{2, 3, 5, 8, 16, 7, 33, 64, 11};
      tracker      = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      no_idle      = 1'b0;
      hold_off_req = 1'b0;
      sizes_tried  = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      foreach (phase_sizes[p]) begin
         run_random_phase(phase_sizes[p], 55, phase_sizes[p] == 8, phase_sizes[p] == 16);
      end

      req_valid <= 1'b0;
      while (tracker.expected_ends.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d length loads and %0d joint angles over %0d chain sizes, 0 to 64",
               tracker.loads_seen, tracker.angles_seen, sizes_tried);
      $display("%0d end points compared, %0d mismatches", tracker.ends_checked, tracker.errors);
      if (tracker.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
